/* design/akvt_pkg.sv */
// Shared types and codes for the associative key/value table.
package akvt_pkg;

    // Request modes
    localparam logic [1:0] MODE_GET = 2'd0;
    localparam logic [1:0] MODE_SET = 2'd1;
    localparam logic [1:0] MODE_DEL = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_MISS     = 2'd0;
    localparam logic [1:0] ST_HIT      = 2'd1;
    localparam logic [1:0] ST_INSERTED = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // Control part of the request token that walks the cell chain
    typedef struct packed {
        logic       vld;
        logic [1:0] mode;
        logic       found;
        logic       free_seen;
    } t_ctl;

endpackage

/* design/akvt_cell.sv */
// One table slot: stored key, value and valid mark, plus one stage of the request token.
module akvt_cell #(
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32,
    parameter int IDX_BITS   = 4,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  akvt_pkg::t_ctl        i_ctl,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [VALUE_BITS-1:0] i_val,
    input  logic [VALUE_BITS-1:0] i_rd,
    input  logic [IDX_BITS-1:0]   i_free_idx,
    input  logic                  i_ins_en,
    input  logic [IDX_BITS-1:0]   i_ins_idx,
    input  logic [KEY_BITS-1:0]   i_ins_key,
    input  logic [VALUE_BITS-1:0] i_ins_val,
    output akvt_pkg::t_ctl        o_ctl,
    output logic [KEY_BITS-1:0]   o_key,
    output logic [VALUE_BITS-1:0] o_val,
    output logic [VALUE_BITS-1:0] o_rd,
    output logic [IDX_BITS-1:0]   o_free_idx
);
    import akvt_pkg::*;

    // slot contents
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic                  r_valid;

    // token stage
    t_ctl                  r_ctl;
    logic [KEY_BITS-1:0]   r_tok_key;
    logic [VALUE_BITS-1:0] r_tok_val;
    logic [VALUE_BITS-1:0] r_tok_rd;
    logic [IDX_BITS-1:0]   r_tok_free_idx;

    t_ctl                  n_ctl;
    logic [VALUE_BITS-1:0] n_tok_rd;
    logic [IDX_BITS-1:0]   n_tok_free_idx;

    logic match;
    logic set_hit;
    logic del_hit;
    logic ins_hit;

    assign match   = i_ctl.vld && !i_ctl.found && r_valid && (r_key == i_key);
    assign set_hit = match && (i_ctl.mode == MODE_SET);
    assign del_hit = match && (i_ctl.mode == MODE_DEL);
    assign ins_hit = i_ins_en && (i_ins_idx == IDX_BITS'(INDEX));

    always_comb begin
        n_ctl          = i_ctl;
        n_tok_rd       = i_rd;
        n_tok_free_idx = i_free_idx;
        if (match) begin
            n_ctl.found = 1'b1;
            if (i_ctl.mode == MODE_GET) begin
                n_tok_rd = r_value;
            end
        end
        // remember the lowest free slot for a possible insert
        if (i_ctl.vld && !r_valid && !i_ctl.free_seen) begin
            n_ctl.free_seen = 1'b1;
            n_tok_free_idx  = IDX_BITS'(INDEX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_ctl   <= '0;
        end else begin
            r_ctl <= n_ctl;
            if (ins_hit) begin
                r_valid <= 1'b1;
            end else if (del_hit) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok_key      <= i_key;
        r_tok_val      <= i_val;
        r_tok_rd       <= n_tok_rd;
        r_tok_free_idx <= n_tok_free_idx;
        if (ins_hit) begin
            r_key   <= i_ins_key;
            r_value <= i_ins_val;
        end else if (set_hit) begin
            r_value <= i_val;
        end
    end

    assign o_ctl      = r_ctl;
    assign o_key      = r_tok_key;
    assign o_val      = r_tok_val;
    assign o_rd       = r_tok_rd;
    assign o_free_idx = r_tok_free_idx;

endmodule

/* design/associative_key_value_table.sv */
// Key/value table: a request token walks a chain of ENTRIES slot cells, one cell per cycle.
// Each result goes from the last cell to a hold register, then to an output register that
// keeps it while the output stalls. One request walks the chain at a time: input stalls
// until the result leaves the hold; a new request is taken while a result still waits.
// Reset (synchronous, active low) clears all valid marks and empties the pipeline;
// keys and values are not cleared.
module associative_key_value_table #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_mode,
    input  logic [KEY_BITS-1:0]   i_lookup_key,
    input  logic [VALUE_BITS-1:0] i_new_value,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_status,
    output logic [VALUE_BITS-1:0] o_read_value
);
    import akvt_pkg::*;

    localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    t_ctl                  c_ctl [ENTRIES+1];
    logic [KEY_BITS-1:0]   c_key [ENTRIES+1];
    logic [VALUE_BITS-1:0] c_val [ENTRIES+1];
    logic [VALUE_BITS-1:0] c_rd  [ENTRIES+1];
    logic [IDX_BITS-1:0]   c_free[ENTRIES+1];

    logic                  accept;
    logic                  chain_exit;
    logic                  ins_en;
    logic                  move;
    logic [1:0]            n_status;

    logic                  r_busy;
    logic                  r_hold_vld;
    logic [1:0]            r_hold_status;
    logic [VALUE_BITS-1:0] r_hold_rd;
    logic                  r_out_valid;
    logic [1:0]            r_out_status;
    logic [VALUE_BITS-1:0] r_out_rd;

    assign accept     = i_in_valid && !r_busy;
    assign o_in_stall = r_busy;

    // token enters the first cell
    assign c_ctl[0]  = '{vld: accept, mode: i_mode, found: 1'b0, free_seen: 1'b0};
    assign c_key[0]  = i_lookup_key;
    assign c_val[0]  = i_new_value;
    assign c_rd[0]   = '0;
    assign c_free[0] = '0;

    assign chain_exit = c_ctl[ENTRIES].vld;
    assign ins_en     = chain_exit && (c_ctl[ENTRIES].mode == MODE_SET)
                        && !c_ctl[ENTRIES].found && c_ctl[ENTRIES].free_seen;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        akvt_cell #(
            .KEY_BITS  (KEY_BITS),
            .VALUE_BITS(VALUE_BITS),
            .IDX_BITS  (IDX_BITS),
            .INDEX     (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (c_ctl[g]),
            .i_key     (c_key[g]),
            .i_val     (c_val[g]),
            .i_rd      (c_rd[g]),
            .i_free_idx(c_free[g]),
            .i_ins_en  (ins_en),
            .i_ins_idx (c_free[ENTRIES]),
            .i_ins_key (c_key[ENTRIES]),
            .i_ins_val (c_val[ENTRIES]),
            .o_ctl     (c_ctl[g+1]),
            .o_key     (c_key[g+1]),
            .o_val     (c_val[g+1]),
            .o_rd      (c_rd[g+1]),
            .o_free_idx(c_free[g+1])
        );
    end

    always_comb begin
        n_status = ST_MISS;
        if (c_ctl[ENTRIES].found
                && (c_ctl[ENTRIES].mode inside {MODE_GET, MODE_SET, MODE_DEL})) begin
            n_status = ST_HIT;
        end else if (c_ctl[ENTRIES].mode == MODE_SET) begin
            n_status = c_ctl[ENTRIES].free_seen ? ST_INSERTED : ST_FULL;
        end
    end

    assign move = r_hold_vld && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_hold_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (move) begin
                r_busy <= 1'b0;
            end
            if (chain_exit) begin
                r_hold_vld <= 1'b1;
            end else if (move) begin
                r_hold_vld <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (chain_exit) begin
            r_hold_status <= n_status;
            r_hold_rd     <= c_rd[ENTRIES];
        end
        if (move) begin
            r_out_status <= r_hold_status;
            r_out_rd     <= r_hold_rd;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_read_value = r_out_rd;

endmodule

/* design/akvt_checker.sv */
// Port-level checker for the key/value table, bound to the top level.
module akvt_checker #(
    parameter int VALUE_BITS = 32
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_stall,
    input logic                  i_out_valid,
    input logic                  i_out_stall,
    input logic [1:0]            i_status,
    input logic [VALUE_BITS-1:0] i_read_value
);
    import akvt_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_status)
            && $stable(i_read_value))
        else $error("stalled result changed");

    // a nonzero value only comes with a hit
    a_rd_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_read_value != '0) |-> i_status == ST_HIT)
        else $error("read value without hit");

    // one item in flight: block input right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_stall |=> i_in_stall)
        else $error("second item taken while busy");

    // no result straight out of reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind associative_key_value_table akvt_checker #(.VALUE_BITS(VALUE_BITS)) u_akvt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_status    (o_status),
    .i_read_value(o_read_value)
);
